>>> hdl/adpc_pkg.sv
package adpc_pkg;

  localparam int NVel = 32;
  localparam int NCd = 16;
  localparam int TableWords = NVel * NCd;
  localparam int TableAw = $clog2(TableWords);
  localparam int ColW = $clog2(NCd);
  localparam int RowW = $clog2(NVel);
  localparam logic [31:0] DtNominalUs = 32'd10000;
  localparam logic signed [31:0] PosMin = 32'sd0;
  localparam logic signed [31:0] PosMax = 32'sd196608;

  // register indexes
  localparam logic [2:0] RegVelMin = 3'd0;
  localparam logic [2:0] RegVelStep = 3'd1;
  localparam logic [2:0] RegCdMin = 3'd2;
  localparam logic [2:0] RegCdStep = 3'd3;
  localparam logic [2:0] RegTarget = 3'd4;
  localparam logic [2:0] RegGainP = 3'd5;
  localparam logic [2:0] RegGainI = 3'd6;
  localparam logic [2:0] RegDeadband = 3'd7;

  localparam logic OpLoad = 1'b0;

  typedef struct packed {
    logic              op;
    logic [8:0]        table_index;
    logic [19:0]       table_value;
    logic signed [15:0] accel_up;
    logic signed [23:0] altitude;
    logic signed [19:0] velocity;
    logic [15:0]       measured_cd;
    logic signed [31:0] motor_pos;
    logic [31:0]       time_us;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] motor_target;
    logic [15:0]       desired_cd;
    logic              controller_active;
  } out_item_t;

  typedef struct packed {
    logic signed [19:0] vel_min;
    logic [18:0]       vel_step;
    logic [15:0]       cd_min;
    logic [15:0]       cd_step;
    logic [22:0]       goal_alt;
    logic [30:0]       gain_p;
    logic [30:0]       gain_i;
    logic [15:0]       drag_deadband;
  } cfg_t;

  typedef enum logic [4:0] {
    S_IDLE, S_PREP, S_CLAMP, S_DIV, S_REM, S_RD0, S_RD1, S_MUL0, S_MUL1,
    S_GDIV, S_CMP, S_ERR, S_PMUL, S_PSUM, S_IMUL, S_IMUL2, S_ISUM, S_OUT, S_HOLD
  } state_e;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic start;
    logic load;
    logic prep;
    logic clamp;
    logic div_start;
    logic rem;
    logic rd0;
    logic rd1;
    logic mul0;
    logic mul1;
    logic gdiv_start;
    logic cmp;
    logic err;
    logic pmul;
    logic psum;
    logic imul;
    logic imul2;
    logic isum;
    logic out;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic last_col;
    logic burn;
  } sts_t;

endpackage

>>> hdl/adpc_ram.sv
module adpc_ram #(
  parameter int Width = 20,
  parameter int Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // one write port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hdl/adpc_div.sv
module adpc_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [44:0] dividend_i,
  input  logic [18:0] divisor_i,
  output logic [44:0] quot_o,
  output logic [18:0] rem_o,
  output logic        done_o
);

  logic [44:0] quot_q, quot_d;
  logic [19:0] rem_q, rem_d;
  logic [18:0] dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [19:0] trial;

  // restoring divider, one quotient bit per cycle
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[18:0], quot_q[44]};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = 6'd45;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
        quot_d = {quot_q[43:0], 1'b1};
      end else begin
        rem_d = trial;
        quot_d = {quot_q[43:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign quot_o = quot_q;
  assign rem_o  = rem_q[18:0];
  assign done_o = !busy_q && !start_i;

endmodule

>>> hdl/adpc_ctrl.sv
module adpc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           go_i,
  input  logic           load_i,
  input  logic           out_ready_i,
  input  adpc_pkg::sts_t sts_i,
  output adpc_pkg::cmd_t cmd_o,
  output logic           busy_o,
  output logic           out_valid_o
);
  import adpc_pkg::*;

  state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (go_i) state_d = S_PREP;
      S_PREP:  state_d = sts_i.burn ? S_OUT : S_CLAMP;
      S_CLAMP: state_d = S_DIV;
      S_DIV:   if (sts_i.div_done) state_d = S_REM;
      S_REM:   state_d = S_RD0;
      S_RD0:   state_d = S_RD1;
      S_RD1:   state_d = S_MUL0;
      S_MUL0:  state_d = S_MUL1;
      S_MUL1:  state_d = S_GDIV;
      S_GDIV:  if (sts_i.div_done) state_d = S_CMP;
      S_CMP:   state_d = sts_i.last_col ? S_ERR : S_RD0;
      S_ERR:   state_d = S_PMUL;
      S_PMUL:  state_d = S_PSUM;
      S_PSUM:  state_d = S_IMUL;
      S_IMUL:  state_d = S_IMUL2;
      S_IMUL2: state_d = S_ISUM;
      S_ISUM:  state_d = S_OUT;
      S_OUT:   state_d = S_HOLD;
      S_HOLD:  if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // command decode
  always_comb begin
    cmd_o = '0;
    cmd_o.start = (state_q == S_IDLE) && go_i;
    cmd_o.load = (state_q == S_IDLE) && load_i;
    case (state_q)
      S_PREP:  cmd_o.prep = 1'b1;
      S_CLAMP: begin
        cmd_o.clamp = 1'b1;
        cmd_o.div_start = 1'b1;
      end
      S_REM:   cmd_o.rem = 1'b1;
      S_RD0:   cmd_o.rd0 = 1'b1;
      S_RD1:   cmd_o.rd1 = 1'b1;
      S_MUL0:  cmd_o.mul0 = 1'b1;
      S_MUL1:  begin
        cmd_o.mul1 = 1'b1;
        cmd_o.gdiv_start = 1'b1;
      end
      S_CMP:   cmd_o.cmp = 1'b1;
      S_ERR:   cmd_o.err = 1'b1;
      S_PMUL:  cmd_o.pmul = 1'b1;
      S_PSUM:  cmd_o.psum = 1'b1;
      S_IMUL:  cmd_o.imul = 1'b1;
      S_IMUL2: cmd_o.imul2 = 1'b1;
      S_ISUM:  cmd_o.isum = 1'b1;
      S_OUT:   cmd_o.out = 1'b1;
      default: ;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_HOLD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hdl/adpc_dp.sv
module adpc_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  adpc_pkg::cfg_t      cfg_i,
  input  adpc_pkg::in_item_t  item_i,
  input  adpc_pkg::cmd_t      cmd_i,
  output adpc_pkg::sts_t      sts_o,
  output adpc_pkg::out_item_t res_o
);
  import adpc_pkg::*;

  // captured item
  in_item_t item_q;
  // persistent loop state
  logic              active_q;
  logic [31:0]       last_time_q;
  logic signed [33:0] integ_q;

  logic [18:0]       step;
  logic signed [25:0] vmin_x, vmax, v_q, v_clamp;
  logic [25:0]       voff;
  logic [RowW-1:0]   row_q;
  logic [18:0]       rem_q;
  logic [ColW-1:0]   col_q;
  logic [39:0]       m0_q, m1_q;
  logic [44:0]       div_a;
  logic [18:0]       div_b;
  logic [44:0]       quot;
  logic [18:0]       drem;
  logic              div_done;
  logic              div_start;
  logic signed [26:0] aperr;
  logic [26:0]       aperr_abs;
  logic [26:0]       best_err_q;
  logic [15:0]       best_cd_q;
  logic [16:0]       cd_cand_q;
  logic [31:0]       dt_q;
  logic signed [16:0] e_q;
  logic signed [48:0] pprod_q;
  logic signed [33:0] p_q;
  logic signed [48:0] iprod_q;
  logic signed [65:0] iprod2_q;
  logic signed [33:0] t_q;
  logic [31:0]       dtraw;
  logic [RowW-1:0]   div_row;
  logic [19:0]       rdata;
  logic [TableAw-1:0] raddr;
  logic              sel_hi_q;
  logic [16:0]       eabs;

  function automatic logic signed [33:0] clampp(input logic signed [41:0] v);
    logic signed [41:0] r;
    r = v;
    if (r < 42'(PosMin)) r = 42'(PosMin);
    if (r > 42'(PosMax)) r = 42'(PosMax);
    return 34'(r);
  endfunction

  // velocity limits of the table and the clamped offset into it
  assign step = (cfg_i.vel_step == '0) ? 19'd1 : cfg_i.vel_step;
  assign vmin_x = 26'(cfg_i.vel_min);
  assign vmax = vmin_x + 26'(26'(step) * 26'(NVel - 1));
  assign v_clamp = (v_q < vmin_x) ? vmin_x : ((v_q > vmax) ? vmax : v_q);
  assign voff = 26'(v_clamp - vmin_x);

  // shared divider: row search, then gain per column
  assign div_start = cmd_i.div_start || cmd_i.gdiv_start;
  assign div_a = cmd_i.div_start ? 45'(voff) : 45'(m0_q + m1_q);
  assign div_b = step;

  adpc_div u_div (
    .clk_i,
    .rst_ni,
    .start_i   (div_start),
    .dividend_i(div_a),
    .divisor_i (div_b),
    .quot_o    (quot),
    .rem_o     (drem),
    .done_o    (div_done)
  );

  assign div_row = (quot > 45'(NVel - 2)) ? RowW'(NVel - 2) : quot[RowW-1:0];

  // table: loads write directly from the input beat
  assign raddr = {sel_hi_q ? row_q + RowW'(1) : row_q, col_q};

  adpc_ram #(.Width(20), .Depth(TableWords)) u_ram (
    .clk_i,
    .we_i   (cmd_i.load),
    .waddr_i(item_i.table_index[TableAw-1:0]),
    .wdata_i(item_i.table_value),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign aperr = 27'(item_q.altitude) + 27'(quot) - 27'(cfg_i.goal_alt);
  assign aperr_abs = aperr[26] ? -aperr : aperr;
  assign dtraw = item_q.time_us - last_time_q;
  assign eabs = e_q[16] ? 17'(-e_q) : 17'(e_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) item_q <= item_i;
    if (cmd_i.prep) begin
      v_q <= 26'(item_q.velocity);
      col_q <= '0;
      sel_hi_q <= 1'b0;
      cd_cand_q <= 17'(cfg_i.cd_min);
      best_err_q <= '1;
      if (active_q && dtraw != 32'd0 && dtraw < 32'd1000000) dt_q <= dtraw;
      else dt_q <= DtNominalUs;
    end
    if (cmd_i.clamp) begin
      v_q <= v_clamp;
      if (dt_q < 32'd100 || dt_q > 32'd50000) dt_q <= DtNominalUs;
    end
    if (cmd_i.rem) begin
      row_q <= div_row;
      rem_q <= 19'(voff - 26'(26'(div_row) * 26'(step)));
    end
    if (cmd_i.rd0) sel_hi_q <= 1'b1;
    // lower row word arrives here, upper row word in the mul0 state that follows
    if (cmd_i.rd1) begin
      sel_hi_q <= 1'b0;
      m0_q <= 40'(rdata) * 40'(step - rem_q);
    end
    if (cmd_i.mul0) m1_q <= 40'(rdata) * 40'(rem_q);
    if (cmd_i.cmp) begin
      if (aperr_abs < best_err_q || col_q == '0) begin
        best_err_q <= aperr_abs;
        best_cd_q <= cd_cand_q[16] ? 16'hffff : cd_cand_q[15:0];
      end
      col_q <= col_q + ColW'(1);
      cd_cand_q <= (cd_cand_q[16]) ? cd_cand_q : cd_cand_q + 17'(cfg_i.cd_step);
    end
    if (cmd_i.err) begin
      e_q <= 17'(best_cd_q) - 17'(item_q.measured_cd);
    end
    if (cmd_i.pmul) begin
      if (eabs < 17'(cfg_i.drag_deadband)) e_q <= '0;
      pprod_q <= $signed({1'b0, cfg_i.gain_p}) * ((eabs < 17'(cfg_i.drag_deadband)) ?
                 17'sd0 : e_q);
    end
    if (cmd_i.psum) begin
      p_q <= 34'(pprod_q / 49'sd16384);
      iprod_q <= $signed({1'b0, cfg_i.gain_i}) * e_q;
    end
    if (cmd_i.imul) begin
      t_q <= clampp(42'(integ_q) + 42'(p_q));
      iprod2_q <= 66'(iprod_q) * $signed({1'b0, dt_q[16:0]});
    end
  end

  // persistent state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      last_time_q <= '0;
      integ_q <= 34'(PosMin);
    end else begin
      if (cmd_i.prep) begin
        last_time_q <= item_q.time_us;
        if (item_q.accel_up >= 0) begin
          active_q <= 1'b0;
          integ_q <= 34'(PosMin);
        end else if (!active_q) begin
          active_q <= 1'b1;
          integ_q <= 34'(item_q.motor_pos);
        end
      end
      if (cmd_i.isum) begin
        if (!((t_q >= 34'(PosMax) && e_q > 0) || (t_q <= 34'(PosMin) && e_q < 0))) begin
          integ_q <= clampp(42'(integ_q) + 42'(iprod2_q / 66'sd16777216));
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out) begin
      if (item_q.accel_up >= 0) begin
        res_o.motor_target <= PosMin;
        res_o.desired_cd <= item_q.measured_cd;
        res_o.controller_active <= 1'b0;
      end else begin
        res_o.motor_target <= 32'(clampp(42'(integ_q) + 42'(p_q)));
        res_o.desired_cd <= best_cd_q;
        res_o.controller_active <= 1'b1;
      end
    end
  end

  assign sts_o.div_done = div_done;
  assign sts_o.last_col = (col_q == ColW'(NCd - 1));
  assign sts_o.burn = (item_q.accel_up >= 0);

  logic unused_ok;
  assign unused_ok = ^{drem, cmd_i.imul2, cmd_i.mul1};

endmodule

>>> hdl/airbrake_drag_pi_controller.sv
// Airbrake drag PI controller. Load beats (op 0) write one coast-table word
// on acceptance and give no result. A control beat while burning passes the
// prep and output states, then holds its result. In flight the row search is
// a 45-bit division on the shared restoring divider, then each of the 16 drag
// columns takes two table reads, two products and one division, then the PI
// update runs its error, product and sum states before the result is
// registered. One beat is in work at a time; the result sits in an output
// register until taken, and the next beat is accepted the cycle after that.
module airbrake_drag_pi_controller (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  adpc_pkg::in_item_t       in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output adpc_pkg::out_item_t      out_data_o,
  input  logic                     cfg_we_i,
  input  logic [2:0]               cfg_index_i,
  input  logic [30:0]              cfg_data_i
);
  import adpc_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;
  logic busy;
  logic go;
  logic load;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vel_min <= '0;
      cfg_q.vel_step <= 19'd640;
      cfg_q.cd_min <= '0;
      cfg_q.cd_step <= 16'd1024;
      cfg_q.goal_alt <= 23'd48768;
      cfg_q.gain_p <= 31'd65536;
      cfg_q.gain_i <= 31'd64;
      cfg_q.drag_deadband <= 16'd16;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegVelMin:   cfg_q.vel_min <= cfg_data_i[19:0];
        RegVelStep:  cfg_q.vel_step <= cfg_data_i[18:0];
        RegCdMin:    cfg_q.cd_min <= cfg_data_i[15:0];
        RegCdStep:   cfg_q.cd_step <= cfg_data_i[15:0];
        RegTarget:   cfg_q.goal_alt <= cfg_data_i[22:0];
        RegGainP:    cfg_q.gain_p <= cfg_data_i;
        RegGainI:    cfg_q.gain_i <= cfg_data_i;
        RegDeadband: cfg_q.drag_deadband <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = !busy;
  // load beats finish on acceptance
  assign go = in_valid_i && !busy && in_data_i.op != OpLoad;
  assign load = in_valid_i && !busy && in_data_i.op == OpLoad;

  adpc_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .go_i       (go),
    .load_i     (load),
    .out_ready_i,
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy_o     (busy),
    .out_valid_o
  );

  adpc_dp u_dp (
    .clk_i,
    .rst_ni,
    .cfg_i (cfg_q),
    .item_i(in_data_i),
    .cmd_i (cmd),
    .sts_o (sts),
    .res_o (out_data_o)
  );

`ifndef NO_ASSERTIONS
  // no input taken while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> !in_ready_o)
    else $error("input accepted with result pending");
  // a held result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");
  // a result says active only when not burning
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.controller_active |-> !sts.burn)
    else $error("active result while burning");
`endif

endmodule

>>> tb/sv/testbench.sv
module testbench;
  import adpc_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_item_t   out_data_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [30:0] cfg_data_i;

  airbrake_drag_pi_controller uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  localparam int StallLimit = 40000;
  localparam int DrainCycles = 40;

  // clock
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // predictor state
  logic [19:0]        coast_tbl [TableWords];
  logic [30:0]        regs [8];
  logic               loop_on;
  logic [31:0]        prev_time;
  longint             integ;

  in_item_t  pending_beats [$];
  out_item_t expected_results [$];

  int  n_errors;
  int  n_loads;
  int  n_burn;
  int  n_flight;
  int  idle_cycles;
  bit  quiet;
  bit  in_taken;
  int  hold_off;
  int  send_gap;
  int  recv_gap;
  logic [31:0] clock_us;

  function automatic longint clamp_pos(longint v);
    if (v < longint'(PosMin)) v = longint'(PosMin);
    if (v > longint'(PosMax)) v = longint'(PosMax);
    return v;
  endfunction

  // apogee search plus PI update, one control or load beat
  task automatic predict_beat(input in_item_t it);
    logic [31:0] d;
    longint dt, alt, vel, vmin, vstep, vmax, row, rem, a0, a1, gain;
    longint e, best_err, cd, err, p_term, i_term, t;
    logic [15:0] best_cd;
    out_item_t r;
    best_cd = '0;
    if (it.op == OpLoad) begin
      coast_tbl[it.table_index] = it.table_value;
      n_loads++;
      return;
    end
    if ($signed(it.accel_up) >= 0) begin
      loop_on = 1'b0;
      integ = longint'(PosMin);
      prev_time = it.time_us;
      r.motor_target = PosMin;
      r.desired_cd = it.measured_cd;
      r.controller_active = 1'b0;
      expected_results.push_back(r);
      n_burn++;
      return;
    end
    dt = 10000;
    d = it.time_us - prev_time;
    if (loop_on && d > 0 && d < 32'd1000000) dt = longint'(d);
    prev_time = it.time_us;
    if (!loop_on) begin
      loop_on = 1'b1;
      integ = longint'($signed(it.motor_pos));
    end
    if (dt < 100 || dt > 50000) dt = 10000;
    alt = longint'($signed(it.altitude));
    vmin = longint'($signed(regs[RegVelMin][19:0]));
    vstep = longint'(regs[RegVelStep][18:0]);
    if (vstep == 0) vstep = 1;
    vmax = vmin + vstep * (NVel - 1);
    vel = longint'($signed(it.velocity));
    if (vel < vmin) vel = vmin;
    if (vel > vmax) vel = vmax;
    row = (vel - vmin) / vstep;
    if (row > NVel - 2) row = NVel - 2;
    rem = vel - vmin - row * vstep;
    best_err = -1;
    for (int col = 0; col < NCd; col++) begin
      a0 = longint'(coast_tbl[row * NCd + col]);
      a1 = longint'(coast_tbl[(row + 1) * NCd + col]);
      gain = (a0 * (vstep - rem) + a1 * rem) / vstep;
      e = alt + gain - longint'(regs[RegTarget][22:0]);
      if (e < 0) e = -e;
      if (best_err < 0 || e < best_err) begin
        best_err = e;
        cd = longint'(regs[RegCdMin][15:0]) + longint'(regs[RegCdStep][15:0]) * col;
        best_cd = (cd > 65535) ? 16'hffff : cd[15:0];
      end
    end
    err = longint'(best_cd) - longint'(it.measured_cd);
    if ((err < 0 ? -err : err) < longint'(regs[RegDeadband][15:0])) err = 0;
    p_term = (longint'(regs[RegGainP]) * err) / 16384;
    t = clamp_pos(integ + p_term);
    if (!((t >= longint'(PosMax) && err > 0) || (t <= longint'(PosMin) && err < 0))) begin
      i_term = (longint'(regs[RegGainI]) * dt * err) / 16777216;
      integ = clamp_pos(integ + i_term);
    end
    t = clamp_pos(integ + p_term);
    r.motor_target = t[31:0];
    r.desired_cd = best_cd;
    r.controller_active = 1'b1;
    expected_results.push_back(r);
    n_flight++;
  endtask

  // input accept, result check, watchdog
  always @(posedge clk_i) begin
    in_taken = in_valid_i && in_ready_o;
    if (in_taken) predict_beat(in_data_i);
    if (out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual %h", $time, out_data_o);
        n_errors++;
      end else begin
        out_item_t x;
        x = expected_results.pop_front();
        if (x.motor_target !== out_data_o.motor_target) begin
          $display("%0t: motor_target expected %0d actual %0d", $time,
                   x.motor_target, out_data_o.motor_target);
          n_errors++;
        end
        if (x.desired_cd !== out_data_o.desired_cd) begin
          $display("%0t: desired_cd expected %0d actual %0d", $time,
                   x.desired_cd, out_data_o.desired_cd);
          n_errors++;
        end
        if (x.controller_active !== out_data_o.controller_active) begin
          $display("%0t: controller_active expected %0b actual %0b", $time,
                   x.controller_active, out_data_o.controller_active);
          n_errors++;
        end
      end
    end
    if (in_taken || (out_valid_o && out_ready_i) || !rst_ni) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $display("%0t: no beat moved for %0d cycles", $time, StallLimit);
      $display("testbench: done, errors");
      $finish;
    end
  end

  // input driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_beats.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(1, 7) - 1;
        in_valid_i <= 1'b0;
      end else begin
        in_data_i <= pending_beats.pop_front();
        in_valid_i <= 1'b1;
      end
    end
  end

  // result receiver with bursts of back-pressure
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off--;
      out_ready_i <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ready_i <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      recv_gap = $urandom_range(1, 7) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [30:0] val);
    logic [30:0] mask;
    case (idx)
      RegVelMin:   mask = 31'h000f_ffff;
      RegVelStep:  mask = 31'h0007_ffff;
      RegTarget:   mask = 31'h007f_ffff;
      RegGainP,
      RegGainI:    mask = 31'h7fff_ffff;
      default:     mask = 31'h0000_ffff;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    regs[idx] = val & mask;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all(input logic [30:0] v0, v1, v2, v3, v4, v5, v6, v7);
    write_reg(RegVelMin, v0);
    write_reg(RegVelStep, v1);
    write_reg(RegCdMin, v2);
    write_reg(RegCdStep, v3);
    write_reg(RegTarget, v4);
    write_reg(RegGainP, v5);
    write_reg(RegGainI, v6);
    write_reg(RegDeadband, v7);
  endtask

  // wait until the block has nothing in work
  task automatic drain();
    wait (pending_beats.size() == 0 && !in_valid_i && expected_results.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic in_item_t control_beat(input bit burn);
    in_item_t it;
    longint vmin, span, v;
    it = '0;
    it.op = 1'b1;
    it.table_index = 9'($urandom);
    it.table_value = 20'($urandom);
    it.accel_up = burn ? 16'($urandom_range(0, 32767)) : 16'(-$urandom_range(1, 32768));
    if ($urandom_range(0, 3) == 0) it.altitude = 24'($urandom);
    else it.altitude = 24'(longint'(regs[RegTarget][22:0]) - $urandom_range(0, 1 << 21));
    vmin = longint'($signed(regs[RegVelMin][19:0]));
    span = longint'(regs[RegVelStep][18:0]) * (NVel - 1) + 1;
    if ($urandom_range(0, 3) == 0 || span > 64'd4000000) v = longint'($signed(20'($urandom)));
    else v = vmin + longint'($urandom_range(0, 32'(span - 1)));
    it.velocity = 20'(v);
    it.measured_cd = 16'($urandom);
    if ($urandom_range(0, 3) == 0) it.motor_pos = 32'($urandom);
    else it.motor_pos = 32'($urandom_range(0, 196608));
    // time steps: half in the usable band, the rest mostly degenerate
    case ($urandom_range(0, 9))
      0: clock_us = clock_us;
      1: clock_us = clock_us + $urandom_range(1, 99);
      2: clock_us = clock_us + $urandom_range(50001, 999999);
      3: clock_us = clock_us + $urandom_range(1000000, 32'hffff_ffff);
      4: clock_us = $urandom;
      default: clock_us = clock_us + $urandom_range(100, 50000);
    endcase
    it.time_us = clock_us;
    return it;
  endfunction

  task automatic push_load(input logic [8:0] idx, input logic [19:0] val);
    in_item_t it;
    it = control_beat(1'b0);
    it.op = OpLoad;
    it.table_index = idx;
    it.table_value = val;
    pending_beats.push_back(it);
  endtask

  // flights: a few burn beats, then coast beats, with stray loads mixed in
  task automatic random_flights(input int n_beats);
    int sent;
    sent = 0;
    while (sent < n_beats) begin
      for (int k = $urandom_range(0, 2); k > 0; k--) begin
        pending_beats.push_back(control_beat(1'b1));
        sent++;
      end
      for (int k = $urandom_range(3, 12); k > 0; k--) begin
        if ($urandom_range(0, 3) == 0) push_load(9'($urandom), 20'($urandom));
        else pending_beats.push_back(control_beat($urandom_range(0, 15) == 0));
        sent++;
      end
    end
  endtask

  initial begin
    in_item_t it;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    n_errors = 0;
    n_loads = 0;
    n_burn = 0;
    n_flight = 0;
    idle_cycles = 0;
    quiet = 1'b0;
    in_taken = 1'b0;
    hold_off = 0;
    send_gap = 0;
    recv_gap = 0;
    clock_us = 32'd0;
    loop_on = 1'b0;
    prev_time = '0;
    integ = longint'(PosMin);
    regs[0] = 31'd0;
    regs[1] = 31'd640;
    regs[2] = 31'd0;
    regs[3] = 31'd1024;
    regs[4] = 31'd48768;
    regs[5] = 31'd65536;
    regs[6] = 31'd64;
    regs[7] = 31'd16;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // phase 1: nominal settings, full table, directed corners
    write_all(31'd0, 31'd640, 31'd0, 31'd1024, 31'd48768, 31'd65536, 31'd64, 31'd16);
    for (int i = 0; i < TableWords; i++) push_load(9'(i), 20'($urandom));
    push_load(9'd0, 20'h00000);
    push_load(9'd511, 20'hfffff);
    pending_beats.push_back(control_beat(1'b1));
    it = control_beat(1'b1); it.accel_up = 16'sd0; pending_beats.push_back(it);
    it = control_beat(1'b0); it.accel_up = -16'sd1; it.time_us = 32'h0;
    it.motor_pos = 32'h8000_0000; pending_beats.push_back(it);
    it = control_beat(1'b0); it.accel_up = 16'sh8000; it.time_us = 32'hffff_ffff;
    it.motor_pos = 32'h7fff_ffff; it.velocity = 20'h80000; it.altitude = 24'h800000;
    it.measured_cd = 16'h0; pending_beats.push_back(it);
    it = control_beat(1'b0); it.velocity = 20'h7ffff; it.altitude = 24'h7fffff;
    it.measured_cd = 16'hffff; it.time_us = 32'd40; pending_beats.push_back(it);
    it = control_beat(1'b0); it.time_us = 32'd40; pending_beats.push_back(it);
    it = control_beat(1'b0); it.time_us = 32'd20040; pending_beats.push_back(it);
    it = control_beat(1'b1); it.accel_up = 16'sh7fff; pending_beats.push_back(it);
    random_flights(170);
    drain();

    // phase 2: velocity minimum at its most negative, every other register at its top end, long receiver hold
    write_all(31'h80000, 31'h7ffff, 31'hffff, 31'hffff, 31'h7fffff, 31'h7fffffff,
              31'h7fffffff, 31'hffff);
    hold_off = 3000;
    random_flights(170);
    drain();

    // phase 3: other extremes, zero row spacing
    write_all(31'h7ffff, 31'd0, 31'd0, 31'd1, 31'd0, 31'd0, 31'd0, 31'd0);
    random_flights(170);
    drain();

    // phase 4: random settings, no idling at the end
    write_all(31'($urandom), 31'($urandom_range(1, 4000)), 31'($urandom_range(0, 40000)),
              31'($urandom_range(1, 3000)), 31'($urandom_range(0, 2000000)),
              31'($urandom_range(0, 300000)), 31'($urandom_range(0, 2000)),
              31'($urandom_range(0, 300)));
    random_flights(150);
    wait (pending_beats.size() < 40);
    quiet = 1'b1;
    drain();

    $display("covered %0d table loads, %0d burn steps, %0d closed-loop steps",
             n_loads, n_burn, n_flight);
    $display("over four register settings including both extremes and a long output stall");
    if (n_errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
